[src/btcl_pkg.sv]
package btcl_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 13;

  localparam logic [CFG_INDEX_W-1:0] CFG_VERSION      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FCC_LIMIT_MA = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_VFLOAT_MV    = 2'd2;

  localparam logic [2:0] VER_OFF    = 3'd0;
  localparam logic [2:0] VER_1P8    = 3'd1;
  localparam logic [2:0] VER_SPRINT = 3'd2;
  localparam logic [2:0] VER_1P9    = 3'd3;
  localparam logic [2:0] VER_2P0    = 3'd4;
  localparam logic [2:0] VER_2P1    = 3'd5;

  localparam logic [12:0] FCC_LIMIT_RESET   = 13'd1000;
  localparam logic [12:0] VFLOAT_RESET      = 13'd4000;
  localparam logic [12:0] COOL_HIGH_VOLT_MA = 13'd500;
  localparam logic [9:0]  UV_PER_MV         = 10'd1000;

  typedef enum logic [2:0] {
    ZONE_COLD     = 3'd0,
    ZONE_COOL     = 3'd1,
    ZONE_NORMAL   = 3'd2,
    ZONE_HIGH     = 3'd3,
    ZONE_OVERHEAT = 3'd4
  } zone_t;

  localparam logic [1:0] HEALTH_GOOD     = 2'd0;
  localparam logic [1:0] HEALTH_OVERHEAT = 2'd1;
  localparam logic [1:0] HEALTH_COLD     = 2'd2;

  // temperature thresholds, tenths of a degree
  localparam logic signed [11:0] OH_START        = 12'sd550;
  localparam logic signed [11:0] OH_START_SPRINT = 12'sd530;
  localparam logic signed [11:0] OH_RELEASE      = 12'sd520;
  localparam logic signed [11:0] HI_START        = 12'sd450;
  localparam logic signed [11:0] HI_RELEASE      = 12'sd430;
  localparam logic signed [11:0] HI_RELEASE_SPR  = 12'sd440;
  localparam logic signed [11:0] COLD_START_1P8  = -12'sd100;
  localparam logic signed [11:0] COLD_REL_1P8    = -12'sd50;
  localparam logic signed [11:0] COLD_START_SPR  = -12'sd50;
  localparam logic signed [11:0] COLD_REL_SPR    = -12'sd40;
  localparam logic signed [11:0] COLD_START      = 12'sd0;
  localparam logic signed [11:0] COLD_RELEASE    = 12'sd30;
  localparam logic signed [11:0] COOL_START      = 12'sd100;
  localparam logic signed [11:0] COOL_RELEASE    = 12'sd120;

  typedef struct packed {
    logic signed [11:0] temperature_dd;
    logic [22:0]        battery_uv;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  zone;
    logic        fcc_limited;
    logic [12:0] fcc_ma;
    logic        vfloat_limited;
    logic [12:0] vfloat_out_mv;
    logic [1:0]  health;
  } out_item_t;

endpackage

[src/btcl_stream_if.sv]
interface btcl_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[src/battery_thermal_charge_limiter_core.sv]
// battery thermal charge limiter
// in_ch carries one transaction per check tick: temperature_dd (signed tenths of a
// degree) and battery_uv. out_ch carries a result only when the temperature zone
// changes or the voltage mark flips in a zone that watches it (high, and cool in
// version 2.1); other ticks produce no transaction.
// cfg_we/cfg_index/cfg_wdata write version, fcc_limit_ma and vfloat_mv; write only
// while the block is idle.
// the input stage captures each accepted transaction; the zone logic evaluates it
// from there, and any result it gives is registered and shown on out_ch.
// throughput: one transaction per cycle while out_ch does not stall, set by the single
// input stage feeding the zone logic and the result register.
// when out_ch stalls, the result holds and one more transaction is parked in the
// input stage; in_ch.ready then drops until the result is taken.
// reset: zone normal, voltage mark low, health good, version off (ticks ignored),
// fcc limit 1000 mA, float voltage 4000 mV, both stages empty.
module battery_thermal_charge_limiter_core (
  input  logic                             clk,
  input  logic                             rst_n,
  btcl_stream_if.sink                      in_ch,
  btcl_stream_if.source                    out_ch,
  input  logic                             cfg_we,
  input  logic [btcl_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [btcl_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import btcl_pkg::*;

  logic [2:0]  version_r;
  logic [12:0] fcc_limit_r;
  logic [12:0] vfloat_r;

  logic        s1_v_r, s1_v_nxt;
  in_item_t    s1_r;
  zone_t       zone_r, zone_nxt;
  logic        volt_high_r, volt_high_nxt;
  logic [1:0]  health_r, health_nxt;
  logic        out_v_r, out_v_nxt;
  out_item_t   out_r, out_nxt;

  logic        process;
  logic        ver_ok;
  logic        emit;
  logic        vh;
  logic [23:0] vh_thr;
  zone_t       z;

  function automatic zone_t next_zone(zone_t cur, logic signed [11:0] t, logic [2:0] ver);
    logic signed [11:0] oh_start, oh_rel, hi_rel, cold_start, cold_rel;
    logic               has_cool;
    zone_t              nz;
    oh_start   = OH_START;
    oh_rel     = OH_RELEASE;
    hi_rel     = HI_RELEASE;
    cold_start = COLD_START;
    cold_rel   = COLD_RELEASE;
    has_cool   = 1'b1;
    nz         = cur;
    if (ver == VER_1P8) begin
      cold_start = COLD_START_1P8;
      cold_rel   = COLD_REL_1P8;
      has_cool   = 1'b0;
    end else if (ver == VER_SPRINT) begin
      oh_start   = OH_START_SPRINT;
      hi_rel     = HI_RELEASE_SPR;
      cold_start = COLD_START_SPR;
      cold_rel   = COLD_REL_SPR;
      has_cool   = 1'b0;
    end
    if (t > oh_start && nz != ZONE_OVERHEAT) nz = ZONE_OVERHEAT;
    if (nz == ZONE_OVERHEAT && t < oh_rel) nz = ZONE_HIGH;
    if (t > HI_START && nz != ZONE_HIGH && nz != ZONE_OVERHEAT) nz = ZONE_HIGH;
    if (nz == ZONE_HIGH && t < hi_rel) nz = ZONE_NORMAL;
    if (t < cold_start && nz != ZONE_COLD) nz = ZONE_COLD;
    if (nz == ZONE_COLD && t > cold_rel) nz = ZONE_COOL;
    if (has_cool) begin
      if (t < COOL_START && nz != ZONE_COLD && nz != ZONE_COOL) nz = ZONE_COOL;
      if (nz == ZONE_COOL && t > COOL_RELEASE) nz = ZONE_NORMAL;
    end else if (nz == ZONE_COOL) begin
      nz = ZONE_NORMAL;
    end
    return nz;
  endfunction

  assign process      = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready  = !s1_v_r || process;
  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_r;

  assign ver_ok = (version_r >= VER_1P8) && (version_r <= VER_2P1);

  // floor(uv / 1000) > vfloat  <=>  uv >= 1000 * (vfloat + 1)
  assign vh_thr = 24'({1'b0, vfloat_r} + 14'd1) * 24'(UV_PER_MV);
  assign vh     = {1'b0, s1_r.battery_uv} >= vh_thr;
  assign z      = next_zone(zone_r, s1_r.temperature_dd, version_r);

  always_comb begin
    s1_v_nxt      = s1_v_r;
    zone_nxt      = zone_r;
    volt_high_nxt = volt_high_r;
    health_nxt    = health_r;
    out_v_nxt     = out_v_r;
    out_nxt       = out_r;
    emit          = 1'b0;

    if (out_v_r && out_ch.ready) out_v_nxt = 1'b0;
    if (process) s1_v_nxt = 1'b0;
    if (in_ch.valid && in_ch.ready) s1_v_nxt = 1'b1;

    if (process && ver_ok) begin
      zone_nxt      = z;
      volt_high_nxt = vh;
      if (z != zone_r) emit = 1'b1;
      if (vh != volt_high_r) begin
        if (z == ZONE_HIGH) emit = 1'b1;
        if (version_r == VER_2P1 && z == ZONE_COOL) emit = 1'b1;
      end
    end

    if (emit) begin
      if (version_r >= VER_2P0) begin
        case (z)
          ZONE_OVERHEAT: health_nxt = HEALTH_OVERHEAT;
          ZONE_COLD:     health_nxt = HEALTH_COLD;
          default:       health_nxt = HEALTH_GOOD;
        endcase
      end
      out_v_nxt              = 1'b1;
      out_nxt.zone           = z;
      out_nxt.fcc_limited    = 1'b0;
      out_nxt.fcc_ma         = '0;
      out_nxt.vfloat_limited = 1'b0;
      out_nxt.vfloat_out_mv  = '0;
      out_nxt.health         = health_nxt;
      case (z)
        ZONE_COLD, ZONE_OVERHEAT: begin
          out_nxt.fcc_limited = 1'b1;
        end
        ZONE_HIGH: begin
          out_nxt.fcc_limited = 1'b1;
          if (!vh) begin
            out_nxt.fcc_ma = fcc_limit_r;
            if (version_r >= VER_2P0) begin
              out_nxt.vfloat_limited = 1'b1;
              out_nxt.vfloat_out_mv  = vfloat_r;
            end
          end
        end
        ZONE_COOL: begin
          out_nxt.fcc_limited = 1'b1;
          out_nxt.fcc_ma      = (version_r == VER_2P1 && vh) ? COOL_HIGH_VOLT_MA : fcc_limit_r;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      version_r   <= VER_OFF;
      fcc_limit_r <= FCC_LIMIT_RESET;
      vfloat_r    <= VFLOAT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_VERSION:      version_r   <= cfg_wdata[2:0];
        CFG_FCC_LIMIT_MA: fcc_limit_r <= cfg_wdata;
        CFG_VFLOAT_MV:    vfloat_r    <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      zone_r      <= ZONE_NORMAL;
      volt_high_r <= 1'b0;
      health_r    <= HEALTH_GOOD;
      out_v_r     <= 1'b0;
    end else begin
      s1_v_r      <= s1_v_nxt;
      zone_r      <= zone_nxt;
      volt_high_r <= volt_high_nxt;
      health_r    <= health_nxt;
      out_v_r     <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) s1_r <= in_ch.data;
    out_r <= out_nxt;
  end

`ifndef SYNTHESIS
  a_off_holds_zone: assert property (@(posedge clk) disable iff (!rst_n)
    (!ver_ok && !cfg_we) |=> $stable(zone_r))
    else $error("zone moved while version off");

  a_zone_change_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (process && ver_ok && z != zone_r) |=> out_v_r)
    else $error("zone change without result");

  a_extreme_stops_charge: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && (out_r.zone == ZONE_COLD || out_r.zone == ZONE_OVERHEAT))
      |-> (out_r.fcc_limited && out_r.fcc_ma == '0))
    else $error("cold or overheat result does not stop charging");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s1_v_r && out_v_r && !out_ch.ready))
    else $error("input stalled with room available");
`endif

endmodule
